[hdl/grg_pkg.sv]
// grg_pkg: shared types and constants for the givens rotation generator
// used by givens_rotation_generate and its checker; no dependencies
`timescale 1ns / 1ps

package grg_pkg;

  localparam int unsigned DataW  = 32;
  localparam int unsigned ROutW  = 33;
  localparam int unsigned SqW    = 64;
  localparam int unsigned CsQW   = 31;   // quotient bits of cosine and sine
  localparam int unsigned ZQW    = 32;   // quotient bits of the reciprocal

  localparam int unsigned RtSteps = 32;
  localparam int unsigned CsSteps = CsQW;
  localparam int unsigned ZSteps  = ZQW;

  // pipeline stage map
  localparam int unsigned StIn   = 0;
  localparam int unsigned StSqr  = 1;
  localparam int unsigned StSum  = 2;
  localparam int unsigned StRt0  = 3;
  localparam int unsigned StRnd  = StRt0 + RtSteps;
  localparam int unsigned StDSet = StRnd + 1;
  localparam int unsigned StCs0  = StDSet + 1;
  localparam int unsigned StZSet = StCs0 + CsSteps;
  localparam int unsigned StZ0   = StZSet + 1;
  localparam int unsigned NStage = StZ0 + ZSteps;
  // accept edge to strobe cycle
  localparam int unsigned Latency = NStage + 1;

  localparam logic [DataW-1:0] OneQ30 = 32'h4000_0000;
  localparam logic [DataW-1:0] OneQ16 = 32'h0001_0000;

  typedef struct packed {
    logic              aneg;
    logic              bneg;
    logic              azero;
    logic              bzero;
    logic              a_big;
    logic [DataW-1:0]  amag;
    logic [DataW-1:0]  bmag;
    logic [SqW-1:0]    sqa;
    logic [SqW-1:0]    sqb;
    logic [SqW-1:0]    rem;
    logic [SqW-1:0]    root;
    logic [DataW-1:0]  rmag;
    logic [DataW-1:0]  crem;
    logic [DataW-1:0]  srem;
    logic [CsQW-1:0]   clow;
    logic [CsQW-1:0]   slow;
    logic [CsQW-1:0]   zrem;
    logic [ZQW-1:0]    zlow;
    logic              zsat;
  } item_t;

endpackage

[hdl/givens_rotation_generate.sv]
// givens_rotation_generate: fully pipelined fixed-point plane rotation generator
// depends on grg_pkg for the stage map, widths and the stage record type
`timescale 1ns / 1ps

// pipeline: 32 square-root steps, 31 cosine/sine division steps and 32 reciprocal
// steps lie between the accepting edge and the strobe cycle
// throughput: one transaction per clock; busy_o stays low, the receiver cannot stall
// reset: valid bits clear asynchronously, payload registers are not reset

module givens_rotation_generate (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  output logic                         busy_o,
  input  logic signed [31:0]           a_in_i,
  input  logic signed [31:0]           b_in_i,
  output logic                         valid_o,
  output logic signed [32:0]           r_out_o,
  output logic signed [31:0]           z_out_o,
  output logic signed [31:0]           cosine_o,
  output logic signed [31:0]           sine_o
);

  grg_pkg::item_t pipe_q [grg_pkg::NStage];
  logic [grg_pkg::NStage-1:0] vld_q;

  logic               out_vld_q;
  logic signed [32:0] r_q;
  logic signed [31:0] z_q;
  logic signed [31:0] c_q;
  logic signed [31:0] s_q;

  assign busy_o = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      vld_q     <= {vld_q[grg_pkg::NStage-2:0], start_i};
      out_vld_q <= vld_q[grg_pkg::NStage-1];
    end
  end

  for (genvar s = 0; s < grg_pkg::NStage; s++) begin : g_stage
    grg_pkg::item_t nxt;

    if (s == grg_pkg::StIn) begin : g_in
      always_comb begin
        nxt       = '0;
        nxt.aneg  = a_in_i[31];
        nxt.bneg  = b_in_i[31];
        nxt.amag  = a_in_i[31] ? 32'(-a_in_i) : a_in_i;
        nxt.bmag  = b_in_i[31] ? 32'(-b_in_i) : b_in_i;
        nxt.azero = (a_in_i == '0);
        nxt.bzero = (b_in_i == '0);
        nxt.a_big = nxt.amag > nxt.bmag;
      end
    end else if (s == grg_pkg::StSqr) begin : g_sqr
      always_comb begin
        nxt     = pipe_q[s-1];
        nxt.sqa = 64'(pipe_q[s-1].amag) * 64'(pipe_q[s-1].amag);
        nxt.sqb = 64'(pipe_q[s-1].bmag) * 64'(pipe_q[s-1].bmag);
      end
    end else if (s == grg_pkg::StSum) begin : g_sum
      always_comb begin
        nxt      = pipe_q[s-1];
        nxt.rem  = pipe_q[s-1].sqa + pipe_q[s-1].sqb;
        nxt.root = '0;
      end
    end else if (s < grg_pkg::StRnd) begin : g_rt
      // one root bit per stage, bit weight falls by four each step
      localparam int unsigned Sh = 62 - 2 * (s - grg_pkg::StRt0);
      logic [63:0] bitw;
      logic [63:0] trial;
      always_comb begin
        bitw  = 64'd1 << Sh;
        trial = pipe_q[s-1].root + bitw;
        nxt   = pipe_q[s-1];
        if (pipe_q[s-1].rem >= trial) begin
          nxt.rem  = pipe_q[s-1].rem - trial;
          nxt.root = (pipe_q[s-1].root >> 1) + bitw;
        end else begin
          nxt.root = pipe_q[s-1].root >> 1;
        end
      end
    end else if (s == grg_pkg::StRnd) begin : g_rnd
      always_comb begin
        nxt      = pipe_q[s-1];
        nxt.rmag = pipe_q[s-1].root[31:0]
                   + 32'(pipe_q[s-1].rem > pipe_q[s-1].root);
      end
    end else if (s == grg_pkg::StDSet) begin : g_dset
      // numerators with half the divisor added for rounding
      logic [62:0] nc;
      logic [62:0] ns;
      always_comb begin
        nc = {1'b0, pipe_q[s-1].amag, 30'd0} + 63'(pipe_q[s-1].rmag >> 1);
        ns = {1'b0, pipe_q[s-1].bmag, 30'd0} + 63'(pipe_q[s-1].rmag >> 1);
        nxt      = pipe_q[s-1];
        nxt.crem = nc[62:31];
        nxt.clow = nc[30:0];
        nxt.srem = ns[62:31];
        nxt.slow = ns[30:0];
      end
    end else if (s < grg_pkg::StZSet) begin : g_cs
      logic [32:0] tc;
      logic [32:0] ts;
      logic        gc;
      logic        gs;
      always_comb begin
        tc  = {pipe_q[s-1].crem, pipe_q[s-1].clow[30]};
        ts  = {pipe_q[s-1].srem, pipe_q[s-1].slow[30]};
        gc  = tc >= {1'b0, pipe_q[s-1].rmag};
        gs  = ts >= {1'b0, pipe_q[s-1].rmag};
        nxt      = pipe_q[s-1];
        nxt.crem = gc ? 32'(tc - {1'b0, pipe_q[s-1].rmag}) : tc[31:0];
        nxt.srem = gs ? 32'(ts - {1'b0, pipe_q[s-1].rmag}) : ts[31:0];
        nxt.clow = {pipe_q[s-1].clow[29:0], gc};
        nxt.slow = {pipe_q[s-1].slow[29:0], gs};
      end
    end else if (s == grg_pkg::StZSet) begin : g_zset
      // clow now holds the cosine magnitude
      logic [46:0] nz;
      always_comb begin
        nz       = (47'd1 << 46) + 47'(pipe_q[s-1].clow >> 1);
        nxt      = pipe_q[s-1];
        nxt.zrem = {16'd0, nz[46:32]};
        nxt.zlow = nz[31:0];
        nxt.zsat = {16'd0, nz[46:32]} >= pipe_q[s-1].clow;
      end
    end else begin : g_z
      logic [31:0] tz;
      logic        gz;
      always_comb begin
        tz       = {pipe_q[s-1].zrem, pipe_q[s-1].zlow[31]};
        gz       = tz >= {1'b0, pipe_q[s-1].clow};
        nxt      = pipe_q[s-1];
        nxt.zrem = gz ? 31'(tz - {1'b0, pipe_q[s-1].clow}) : tz[30:0];
        nxt.zlow = {pipe_q[s-1].zlow[30:0], gz};
      end
    end

    always_ff @(posedge clk_i) begin
      pipe_q[s] <= nxt;
    end
  end

  // output formation: special cases, z selection, sign application
  grg_pkg::item_t fin;
  logic        sig;
  logic        cneg;
  logic        sneg;
  logic [32:0] zlim;
  logic [32:0] zmag;
  logic        zneg;
  logic [31:0] zab;
  logic signed [32:0] r_d;
  logic signed [31:0] z_d;
  logic signed [31:0] c_d;
  logic signed [31:0] s_d;

  always_comb begin
    fin  = pipe_q[grg_pkg::NStage-1];
    sig  = fin.a_big ? fin.aneg : fin.bneg;
    cneg = fin.aneg ^ sig;
    sneg = fin.bneg ^ sig;
    zlim = cneg ? 33'h1_0000_0000 >> 1 : 33'h0_7fff_ffff;
    zab  = (32'(fin.slow) + 32'd8192) >> 14;
    if (fin.a_big) begin
      zmag = {1'b0, zab};
      zneg = sneg;
    end else if (fin.clow != '0) begin
      zmag = (fin.zsat || ({1'b0, fin.zlow} > zlim)) ? zlim : {1'b0, fin.zlow};
      zneg = cneg;
    end else begin
      zmag = {1'b0, grg_pkg::OneQ16};
      zneg = 1'b0;
    end

    if (fin.bzero) begin
      r_d = fin.aneg ? -$signed({1'b0, fin.amag}) : $signed({1'b0, fin.amag});
      z_d = '0;
      c_d = grg_pkg::OneQ30;
      s_d = '0;
    end else if (fin.azero) begin
      r_d = fin.bneg ? -$signed({1'b0, fin.bmag}) : $signed({1'b0, fin.bmag});
      z_d = grg_pkg::OneQ16;
      c_d = '0;
      s_d = grg_pkg::OneQ30;
    end else begin
      r_d = sig ? -$signed({1'b0, fin.rmag}) : $signed({1'b0, fin.rmag});
      z_d = zneg ? 32'(-zmag) : zmag[31:0];
      c_d = cneg ? -$signed({1'b0, fin.clow}) : $signed({1'b0, fin.clow});
      s_d = sneg ? -$signed({1'b0, fin.slow}) : $signed({1'b0, fin.slow});
    end
  end

  always_ff @(posedge clk_i) begin
    r_q <= r_d;
    z_q <= z_d;
    c_q <= c_d;
    s_q <= s_d;
  end

  assign valid_o  = out_vld_q;
  assign r_out_o  = r_q;
  assign z_out_o  = z_q;
  assign cosine_o = c_q;
  assign sine_o   = s_q;

endmodule

[hdl/grg_checker.sv]
// grg_checker: port-level checks for givens_rotation_generate, bound to the top
// depends on grg_pkg for the pipeline latency
`timescale 1ns / 1ps

module grg_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               start_i,
  input logic               busy_o,
  input logic signed [31:0] a_in_i,
  input logic signed [31:0] b_in_i,
  input logic               valid_o,
  input logic signed [32:0] r_out_o,
  input logic signed [31:0] z_out_o,
  input logic signed [31:0] cosine_o,
  input logic signed [31:0] sine_o
);

  // every transaction comes out exactly once, a fixed latency later
  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o |-> ##(grg_pkg::Latency) valid_o)
    else $error("transaction lost in pipeline");

  a_no_phantom: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && $past(rst_ni, grg_pkg::Latency)
      |-> $past(start_i && !busy_o, grg_pkg::Latency))
    else $error("result without transaction");

  a_rot_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> cosine_o != '0 || sine_o != '0)
    else $error("degenerate rotation");

  a_b_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && $past(b_in_i, grg_pkg::Latency) == '0
      |-> sine_o == '0 && cosine_o == grg_pkg::OneQ30 && z_out_o == '0)
    else $error("b zero case wrong");

endmodule

bind givens_rotation_generate grg_checker u_grg_checker (.*);

[dv/tb.sv]
// tb: self-checking testbench for givens_rotation_generate
// depends on grg_pkg and the rtl of givens_rotation_generate
`timescale 1ns / 1ps

module tb;

  typedef struct {
    logic [31:0] a;
    logic [31:0] b;
  } pair_t;

  typedef struct {
    logic [32:0] r;
    logic [31:0] z;
    logic [31:0] c;
    logic [31:0] s;
  } rot_t;

  localparam int unsigned WdogLimit = 4000;

  logic               clk_i;
  logic               rst_ni;
  logic               start_i;
  logic               busy_o;
  logic signed [31:0] a_in_i;
  logic signed [31:0] b_in_i;
  logic               valid_o;
  logic signed [32:0] r_out_o;
  logic signed [31:0] z_out_o;
  logic signed [31:0] cosine_o;
  logic signed [31:0] sine_o;

  pair_t pending_q[$];
  rot_t  rot_expected_q[$];
  int    errors;
  int    gap_left;
  int    quiet_cycles;
  bit    stim_done;
  bit    no_idle;

  givens_rotation_generate u_top (
    .clk_i(clk_i), .rst_ni(rst_ni), .start_i(start_i), .busy_o(busy_o),
    .a_in_i(a_in_i), .b_in_i(b_in_i), .valid_o(valid_o), .r_out_o(r_out_o),
    .z_out_o(z_out_o), .cosine_o(cosine_o), .sine_o(sine_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  function automatic logic [63:0] sqrt_nearest(logic [63:0] sq);
    logic [63:0] rem, root, bitv;
    rem  = sq;
    root = 64'd0;
    bitv = 64'd1 << 62;
    while (bitv > rem) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (rem >= root + bitv) begin
        rem  = rem - (root + bitv);
        root = (root >> 1) + bitv;
      end else begin
        root = root >> 1;
      end
      bitv = bitv >> 2;
    end
    if (rem > root) root = root + 1;
    return root;
  endfunction

  function automatic logic [63:0] apply_sign(logic neg, logic [63:0] mag);
    return neg ? (64'd0 - mag) : mag;
  endfunction

  function automatic rot_t predict_rotation(pair_t p);
    rot_t        o;
    logic        aneg, bneg, a_big, sigma, cneg, sneg, zneg;
    logic [63:0] amag, bmag, rmag, cmag, smag, zmag, lim;
    aneg = p.a[31];
    bneg = p.b[31];
    amag = aneg ? (64'h1_0000_0000 - {32'd0, p.a}) : {32'd0, p.a};
    bmag = bneg ? (64'h1_0000_0000 - {32'd0, p.b}) : {32'd0, p.b};
    if (bmag == 0) begin
      o.r = 33'(apply_sign(aneg, amag));
      o.z = '0;
      o.c = grg_pkg::OneQ30;
      o.s = '0;
    end else if (amag == 0) begin
      o.r = 33'(apply_sign(bneg, bmag));
      o.z = grg_pkg::OneQ16;
      o.c = '0;
      o.s = grg_pkg::OneQ30;
    end else begin
      a_big = amag > bmag;
      sigma = a_big ? aneg : bneg;
      rmag  = sqrt_nearest(amag * amag + bmag * bmag);
      cmag  = ((amag << 30) + rmag / 2) / rmag;
      smag  = ((bmag << 30) + rmag / 2) / rmag;
      cneg  = aneg != sigma;
      sneg  = bneg != sigma;
      if (a_big) begin
        zmag = (smag + 8192) >> 14;
        zneg = sneg;
      end else if (cmag != 0) begin
        lim  = cneg ? (64'd1 << 31) : ((64'd1 << 31) - 1);
        zmag = ((64'd1 << 46) + cmag / 2) / cmag;
        if (zmag > lim) zmag = lim;
        zneg = cneg;
      end else begin
        zmag = 64'(grg_pkg::OneQ16);
        zneg = 1'b0;
      end
      o.r = 33'(apply_sign(sigma, rmag));
      o.z = 32'(apply_sign(zneg, zmag));
      o.c = 32'(apply_sign(cneg, cmag));
      o.s = 32'(apply_sign(sneg, smag));
    end
    return o;
  endfunction

  function automatic logic [31:0] rand_operand();
    case ($urandom_range(0, 7))
      0: return 32'h8000_0000 + $urandom_range(0, 3);
      1: return 32'h7fff_ffff - $urandom_range(0, 3);
      2: return $urandom_range(0, 8) - 4;
      3: return 32'($signed($urandom_range(0, 131072)) - 65536);
      4: return '0;
      default: return $urandom;
    endcase
  endfunction

  task automatic add_pair(logic [31:0] a, logic [31:0] b);
    pair_t p;
    p.a = a;
    p.b = b;
    pending_q.push_back(p);
  endtask

  // stimulus
  initial begin
    logic [31:0] x;
    add_pair(32'h0, 32'h0);
    add_pair(32'h7fff_ffff, 32'h0);
    add_pair(32'h8000_0000, 32'h0);
    add_pair(32'h0, 32'h7fff_ffff);
    add_pair(32'h0, 32'h8000_0000);
    add_pair(32'h8000_0000, 32'h8000_0000);
    add_pair(32'h7fff_ffff, 32'h7fff_ffff);
    add_pair(32'h7fff_ffff, 32'h8000_0000);
    add_pair(32'h8000_0000, 32'h7fff_ffff);
    add_pair(32'h0001_0000, 32'h0001_0000);
    add_pair(32'hffff_0000, 32'h0001_0000);
    add_pair(32'h0003_0000, 32'hfffc_0000);
    // cosine rounds to one lsb: tiny a against huge b
    add_pair(32'h0000_0001, 32'h7fff_ffff);
    add_pair(32'hffff_ffff, 32'h8000_0000);
    // reciprocal saturates both ways
    add_pair(32'h0000_0100, 32'h7fff_0000);
    add_pair(32'hffff_ff00, 32'h7fff_0000);
    add_pair(32'h0000_0001, 32'h0000_0001);
    add_pair(32'h0000_0002, 32'hffff_ffff);
    add_pair(32'h7fff_ffff, 32'h0000_0001);
    add_pair(32'h8000_0000, 32'hffff_ffff);
    for (int i = 0; i < 1300; i++) begin
      x = rand_operand();
      if ($urandom_range(0, 9) == 0) add_pair(x, $urandom_range(0, 1) ? x : 32'(-x));
      else add_pair(rand_operand(), rand_operand());
    end
  end

  // driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_i  <= 1'b0;
      a_in_i   <= '0;
      b_in_i   <= '0;
      gap_left <= 0;
    end else begin
      no_idle = pending_q.size() < 200;
      if (start_i && !busy_o) begin
        rot_expected_q.push_back(predict_rotation(pending_q.pop_front()));
      end
      if (!start_i || !busy_o) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          start_i  <= 1'b0;
        end else if (!no_idle && $urandom_range(0, 19) == 0) begin
          gap_left <= $urandom_range(0, 13);
          start_i  <= 1'b0;
        end else if (pending_q.size() > 0) begin
          start_i <= 1'b1;
          a_in_i  <= pending_q[0].a;
          b_in_i  <= pending_q[0].b;
        end else begin
          start_i <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk_i) begin
    rot_t e;
    if (rst_ni && valid_o) begin
      if (rot_expected_q.size() == 0) begin
        $display("%0t: unexpected transaction r=%h", $time, r_out_o);
        errors++;
      end else begin
        e = rot_expected_q.pop_front();
        if (r_out_o !== e.r) begin
          $display("%0t: r_out expected %h actual %h", $time, e.r, r_out_o);
          errors++;
        end
        if (z_out_o !== e.z) begin
          $display("%0t: z_out expected %h actual %h", $time, e.z, z_out_o);
          errors++;
        end
        if (cosine_o !== e.c) begin
          $display("%0t: cosine expected %h actual %h", $time, e.c, cosine_o);
          errors++;
        end
        if (sine_o !== e.s) begin
          $display("%0t: sine expected %h actual %h", $time, e.s, sine_o);
          errors++;
        end
      end
    end
  end

  // watchdog and end of run
  initial begin
    errors       = 0;
    quiet_cycles = 0;
    rst_ni       = 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    forever begin
      @(posedge clk_i);
      if ((start_i && !busy_o) || valid_o) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= WdogLimit) begin
        $display("status: fail");
        $finish;
      end
      if (pending_q.size() == 0 && !start_i && rot_expected_q.size() == 0) begin
        repeat (grg_pkg::Latency + 10) @(posedge clk_i);
        if (errors == 0 && rot_expected_q.size() == 0) begin
          $display("status: pass");
        end else begin
          $display("status: fail");
        end
        $finish;
      end
    end
  end

endmodule

[filelist.f]
hdl/grg_pkg.sv
hdl/givens_rotation_generate.sv
hdl/grg_checker.sv
dv/tb.sv
